[sv/mrf_pkg.sv]
// shared types and constants of the modbus rtu request framer
`timescale 1ns / 1ps

package mrf_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] CFG_READ_FUNC  = 2'd1;
	localparam logic [1:0] CFG_WRITE_FUNC = 2'd2;

	// register values after reset
	localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
	localparam logic [7:0] READ_FUNC_RST  = 8'd3;
	localparam logic [7:0] WRITE_FUNC_RST = 8'd16;

	// frame layout
	localparam int READ_TAIL_BYTES  = 6;
	localparam int WRITE_HEAD_BYTES = 5;
	localparam int QTY_HIGH_POS     = 2;
	localparam int QTY_LOW_POS      = 3;
	localparam int REM_W            = 18;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} result_t;

endpackage

[sv/mrf_out_fifo.sv]
// small result queue that takes up to two results per cycle and hands out one
`timescale 1ns / 1ps

module mrf_out_fifo import mrf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    push_a,
	input  result_t    push_b,
	output logic       room,
	input  logic       pop,
	output result_t    head,
	output logic       not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t        mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW-1:0]  wr_ptr_p1;
	logic [CW-1:0]  count_q;

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [1:0] step);
		logic [AW:0] sum;
		sum = {1'b0, p} + (AW+1)'(step);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign wr_ptr_p1 = ptr_add(wr_ptr_q, 2'd1);
	assign room      = count_q <= CW'(DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= ptr_add(wr_ptr_q, push_n);
			if (pop) begin
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	// never holds more than it has slots for
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overfilled");

	// a push without a pop leaves the queue non-empty
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0 && !pop) |=> not_empty)
		else $error("pushed result lost");

endmodule

[sv/modbus_rtu_request_framer.sv]
// top level of the modbus rtu request framer: byte stepping and config registers
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_ready    rx_byte
//   out       output      out_valid / out_ready  frame_byte, frame_first, frame_last
//   cfg       input       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one received byte is taken per cycle and stepped in that same cycle into the result queue
// a function code byte that opens a frame yields two results (address, code); all others one or none
// results leave one per cycle, so in_ready falls while the queue has fewer than two free slots
// reset: hunting for the address, queue empty, registers at 1 / 3 / 16; cfg_ready is always high
// an output stall only backs up through the OUT_DEPTH-entry queue
`timescale 1ns / 1ps

module modbus_rtu_request_framer import mrf_pkg::*; #(
	parameter int OUT_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       frame_first,
	output logic       frame_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_FUNC = 2'd1;
	localparam logic [1:0] PH_HEAD = 2'd2;
	localparam logic [1:0] PH_BODY = 2'd3;

	logic [7:0]       slave_addr_q;
	logic [7:0]       read_func_q;
	logic [7:0]       write_func_q;

	logic [1:0]       phase_q, phase_d;
	logic [2:0]       head_pos_q, head_pos_d;
	logic [7:0]       qty_high_q, qty_high_d;
	logic [REM_W-1:0] remaining_q, remaining_d;
	logic [2:0]       head_pos_inc;

	logic             in_fire;
	logic [1:0]       push_n;
	result_t          push_a;
	result_t          push_b;
	result_t          head;
	logic             room;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign in_fire   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
			read_func_q  <= READ_FUNC_RST;
			write_func_q <= WRITE_FUNC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDR: slave_addr_q <= cfg_data;
				CFG_READ_FUNC:  read_func_q  <= cfg_data;
				CFG_WRITE_FUNC: write_func_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign head_pos_inc = head_pos_q + 3'd1;

	always_comb begin
		phase_d     = phase_q;
		head_pos_d  = head_pos_q;
		qty_high_d  = qty_high_q;
		remaining_d = remaining_q;
		push_n      = 2'd0;
		push_a      = '{data: rx_byte, first: 1'b0, last: 1'b0};
		push_b      = '{data: rx_byte, first: 1'b0, last: 1'b0};
		if (in_fire) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == slave_addr_q) begin
						phase_d = PH_FUNC;
					end
				end
				PH_FUNC: begin
					// read code wins when both codes match
					priority if (rx_byte == read_func_q) begin
						remaining_d = REM_W'(READ_TAIL_BYTES);
						phase_d     = PH_BODY;
						push_n      = 2'd2;
					end else if (rx_byte == write_func_q) begin
						head_pos_d  = '0;
						qty_high_d  = '0;
						remaining_d = '0;
						phase_d     = PH_HEAD;
						push_n      = 2'd2;
					end else begin
						phase_d = PH_HUNT;
					end
					push_a = '{data: slave_addr_q, first: 1'b1, last: 1'b0};
				end
				PH_HEAD: begin
					if (head_pos_q == 3'(QTY_HIGH_POS)) begin
						qty_high_d = rx_byte;
					end else if (head_pos_q == 3'(QTY_LOW_POS)) begin
						// data bytes plus two crc bytes
						remaining_d = REM_W'({qty_high_q, rx_byte, 1'b0}) + REM_W'(2);
					end
					if (head_pos_inc >= 3'(WRITE_HEAD_BYTES)) begin
						head_pos_d = '0;
						phase_d    = PH_BODY;
					end else begin
						head_pos_d = head_pos_inc;
					end
					push_n = 2'd1;
				end
				PH_BODY: begin
					if (remaining_q <= REM_W'(1)) begin
						remaining_d = '0;
						phase_d     = PH_HUNT;
						push_a.last = 1'b1;
					end else begin
						remaining_d = remaining_q - REM_W'(1);
					end
					push_n = 2'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			head_pos_q  <= '0;
			qty_high_q  <= '0;
			remaining_q <= '0;
		end else begin
			phase_q     <= phase_d;
			head_pos_q  <= head_pos_d;
			qty_high_q  <= qty_high_d;
			remaining_q <= remaining_d;
		end
	end

	mrf_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (push_a),
		.push_b    (push_b),
		.room      (room),
		.pop       (out_valid & out_ready),
		.head      (head),
		.not_empty (out_valid)
	);

	assign frame_byte  = head.data;
	assign frame_first = head.first;
	assign frame_last  = head.last;

	// results only come from an accepted byte
	a_push_needs_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> in_fire)
		else $error("result pushed without an input transfer");

	// an accepted function code leads into the header or body
	a_func_opens_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_FUNC && push_n == 2'd2)
		|=> (phase_q == PH_HEAD || phase_q == PH_BODY))
		else $error("frame open did not advance phase");

	// the quantity byte sets an even, nonzero remaining count
	a_qty_sets_len: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_HEAD && head_pos_q == 3'(QTY_LOW_POS))
		|=> (remaining_q[0] == 1'b0 && remaining_q != '0))
		else $error("bad write frame length");

	// the closing byte returns to hunting
	a_last_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_BODY && remaining_q <= REM_W'(1)) |=> phase_q == PH_HUNT)
		else $error("frame end did not resume hunting");

endmodule
